FILE: design/twda_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twda_pkg: shared types and constants
// Item, configuration and queue-link types for the time-weighted DAC average.
// ---------------------------------------------------------------------------
package twda_pkg;

  localparam int unsigned NowW     = 64;
  localparam int unsigned DacW     = 16;
  localparam int unsigned SampleW  = 24;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned GainW    = 8;
  localparam int unsigned FsW      = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // register indexes on the config port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DAC_BITS   = 2'd0,
    CFG_GAIN       = 2'd1,
    CFG_FULL_SCALE = 2'd2
  } cfg_idx_e;

  localparam logic [ShiftW-1:0]  DAC_BITS_RST   = 5'd8;
  localparam logic [GainW-1:0]   GAIN_RST       = 8'd1;
  localparam logic [FsW-1:0]     FULL_SCALE_RST = 16'd16384;
  localparam logic [SampleW-1:0] SAMPLE_MAX     = '1;

  typedef struct packed {
    logic [ShiftW-1:0] dac_bits;
    logic [GainW-1:0]  gain;
    logic [FsW-1:0]    full_scale;
  } cfg_t;

  typedef struct packed {
    logic            is_read;
    logic [NowW-1:0] now_clock;
    logic [DacW-1:0] dac_value;
  } item_t;

  // queue head as seen by the execution side
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

FILE: design/twda_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twda_front: request intake
// Takes requests off the input stream, tags reads/writes and queues them
// in a two-entry queue for the execution side.
// ---------------------------------------------------------------------------
module twda_front import twda_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_kind_i,
  input  logic [NowW-1:0]      in_now_i,
  input  logic [DacW-1:0]      in_dac_i,
  output q_head_t              head_o,
  input  logic                 pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{is_read: in_kind_i, now_clock: in_now_i, dac_value: in_dac_i};
    end
  end

endmodule

FILE: design/twda_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twda_back: request execution
// Integrates the held code over time and turns the window into one sample
// with a split multiplier and a bit-serial divider.
// ---------------------------------------------------------------------------
module twda_back import twda_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  q_head_t            head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] out_sample_o
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DELTA  = 14'b00000000000010,
    S_MUL_LO = 14'b00000000000100,
    S_MUL_HI = 14'b00000000001000,
    S_SAT    = 14'b00000000010000,
    S_SUM    = 14'b00000000100000,
    S_SCL_LO = 14'b00000001000000,
    S_SCL_HI = 14'b00000010000000,
    S_SHIFT  = 14'b00000100000000,
    S_CHECK  = 14'b00001000000000,
    S_DIV    = 14'b00010000000000,
    S_GAIN   = 14'b00100000000000,
    S_CLIP   = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_e;

  localparam int unsigned ProdW = NowW + DacW;       // 80
  localparam int unsigned PartW = 32 + DacW;         // 48
  localparam logic [SUM_WIDTH-1:0] SumMax = '1;

  state_e state_q, state_d;

  // architectural state
  logic [DacW-1:0]      held_q;
  logic [NowW-1:0]      last_q;
  logic [NowW-1:0]      win_q;
  logic [SUM_WIDTH-1:0] sum_q;

  // working registers
  item_t                item_q;
  logic [NowW-1:0]      elapsed_q;
  logic [NowW-1:0]      ticks_q;
  logic [PartW-1:0]     pp_lo_q;
  logic [PartW-1:0]     pp_hi_q;
  logic [SUM_WIDTH-1:0] prod_q;
  logic [ProdW-1:0]     shifted_q;
  logic [NowW-1:0]      rem_q;
  logic [NowW-1:0]      quo_q;
  logic [5:0]           cnt_q;
  logic [31:0]          gp_q;
  logic [SampleW-1:0]   res_q;
  logic                 out_valid_q;
  logic [SampleW-1:0]   out_data_q;

  logic [ProdW-1:0]     pp_sum;
  logic [SUM_WIDTH:0]   sum_ext;
  logic [63:0]          sum64;
  logic [NowW:0]        r2;
  logic [NowW:0]        diff;
  logic                 out_free;
  logic                 ticks_zero;

  assign pp_sum     = {32'b0, pp_lo_q} + {pp_hi_q, 32'b0};
  assign sum_ext    = {1'b0, sum_q} + {1'b0, prod_q};
  assign sum64      = 64'(sum_q);
  assign r2         = {rem_q, quo_q[NowW-1]};
  assign diff       = r2 - {1'b0, ticks_q};
  assign out_free   = !out_valid_q || out_ready_i;
  assign ticks_zero = (ticks_q == '0);

  assign pop_o        = (state_q == S_IDLE) && head_i.valid;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_data_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (head_i.valid) state_d = S_DELTA;
      S_DELTA:  state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_SAT;
      S_SAT:    state_d = S_SUM;
      S_SUM: begin
        if (!item_q.is_read) state_d = S_IDLE;
        else if (ticks_zero || cfg_i.gain == '0) state_d = S_OUT;
        else state_d = S_SCL_LO;
      end
      S_SCL_LO: state_d = S_SCL_HI;
      S_SCL_HI: state_d = S_SHIFT;
      S_SHIFT:  state_d = S_CHECK;
      S_CHECK:  state_d = (64'(shifted_q[ProdW-1:NowW]) >= ticks_q) ? S_OUT : S_DIV;
      S_DIV:    if (cnt_q == 6'h3F) state_d = S_GAIN;
      S_GAIN:   state_d = (|quo_q[NowW-1:SampleW]) ? S_OUT : S_CLIP;
      S_CLIP:   state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      last_q      <= '0;
      win_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SUM) begin
        last_q <= item_q.now_clock;
        // a read that yields 0 right away restarts the window here
        if (item_q.is_read && (ticks_zero || cfg_i.gain == '0)) begin
          sum_q <= '0;
        end else begin
          sum_q <= sum_ext[SUM_WIDTH] ? SumMax : sum_ext[SUM_WIDTH-1:0];
        end
        if (!item_q.is_read) begin
          held_q <= item_q.dac_value;
        end else begin
          win_q <= item_q.now_clock;
        end
      end
      if (state_q == S_SCL_HI) sum_q <= '0;
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE:   item_q <= head_i.item;
      S_DELTA: begin
        elapsed_q <= item_q.now_clock - last_q;
        ticks_q   <= item_q.now_clock - win_q;
      end
      S_MUL_LO: pp_lo_q <= PartW'(elapsed_q[31:0]) * PartW'(held_q);
      S_MUL_HI: pp_hi_q <= PartW'(elapsed_q[63:32]) * PartW'(held_q);
      S_SAT:    prod_q <= (pp_sum > ProdW'(SumMax)) ? SumMax : pp_sum[SUM_WIDTH-1:0];
      S_SUM:    res_q <= '0;
      S_SCL_LO: pp_lo_q <= PartW'(sum64[31:0]) * PartW'(cfg_i.full_scale);
      S_SCL_HI: pp_hi_q <= PartW'(sum64[63:32]) * PartW'(cfg_i.full_scale);
      S_SHIFT:  shifted_q <= pp_sum >> cfg_i.dac_bits;
      S_CHECK: begin
        res_q <= SAMPLE_MAX;
        rem_q <= 64'(shifted_q[ProdW-1:NowW]);
        quo_q <= shifted_q[NowW-1:0];
        cnt_q <= '0;
      end
      S_DIV: begin
        // restoring step: one quotient bit per cycle
        if (!diff[NowW]) rem_q <= diff[NowW-1:0];
        else rem_q <= r2[NowW-1:0];
        quo_q <= {quo_q[NowW-2:0], ~diff[NowW]};
        cnt_q <= cnt_q + 6'd1;
      end
      S_GAIN: begin
        res_q <= SAMPLE_MAX;
        gp_q  <= {8'd0, quo_q[SampleW-1:0]} * {24'd0, cfg_i.gain};
      end
      S_CLIP:   res_q <= (|gp_q[31:SampleW]) ? SAMPLE_MAX : gp_q[SampleW-1:0];
      S_OUT:    if (out_free) out_data_q <= res_q;
      default:  ;
    endcase
  end

endmodule

FILE: design/time_weighted_dac_average.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// time_weighted_dac_average: time-averaging parallel DAC
// Holds a DAC code between writes, integrates code x elapsed time into a
// saturating accumulator, and on each read emits the window average scaled
// by full_scale >> dac_bits and gain, then restarts the window.
// ---------------------------------------------------------------------------
//
// channel   dir  handshake               payload
// --------  ---  ----------------------  ---------------------------------------
// s_axis    in   s_axis_tvalid/tready    tuser: kind; tdata: now_clock, dac_value
// m_axis    out  m_axis_tvalid/tready    tdata: sample (reads only)
// cfg       in   cfg_we_i                cfg_idx_i selects, cfg_wdata_i value
//
// A write request only folds the elapsed time into the accumulator and
// latches the code; a read also runs the 64-step bit-serial divider (one
// quotient bit per cycle). An empty window or zero gain ends a read with 0
// before the divider, a quotient overflow with the maximum sample.
// A two-entry request queue lets the input keep accepting while the unit is
// busy or the output register waits on m_axis_tready.
// Reset clears the control and accumulator state at once; there is no clearing pass.
// ---------------------------------------------------------------------------
module time_weighted_dac_average import twda_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [79:0]         s_axis_tdata,   // [63:0] now_clock, [79:64] dac_value
  input  logic                s_axis_tuser,   // [0] kind (0 write, 1 read)
  // sample stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SampleW-1:0]  m_axis_tdata,   // [23:0] sample
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  q_head_t head;
  logic    pop;

  // config registers; index 3 is not mapped and is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dac_bits   <= DAC_BITS_RST;
      cfg_q.gain       <= GAIN_RST;
      cfg_q.full_scale <= FULL_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DAC_BITS:   cfg_q.dac_bits   <= cfg_wdata_i[ShiftW-1:0];
        CFG_GAIN:       cfg_q.gain       <= cfg_wdata_i[GainW-1:0];
        CFG_FULL_SCALE: cfg_q.full_scale <= cfg_wdata_i[FsW-1:0];
        default:        ;
      endcase
    end
  end

  twda_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_now_i   (s_axis_tdata[NowW-1:0]),
    .in_dac_i   (s_axis_tdata[NowW+DacW-1:NowW]),
    .head_o     (head),
    .pop_i      (pop)
  );

  twda_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata)
  );

endmodule

FILE: design/twda_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twda_checker: port-level checks
// Tracks reads in flight and checks output behavior against them.
// ---------------------------------------------------------------------------
module twda_checker import twda_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [SampleW-1:0] m_axis_tdata
);

  logic [2:0] pending_q;
  logic       rd_in;
  logic       smp_out;

  assign rd_in   = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign smp_out = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pending_q <= '0;
    else pending_q <= pending_q + 3'(rd_in) - 3'(smp_out);
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("sample changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 3'd0)
    else $error("sample without a read request");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("too many reads in flight");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd4 |-> !s_axis_tready)
    else $error("request accepted with no room left");

endmodule

bind time_weighted_dac_average twda_checker u_twda_checker (.*);

FILE: bench/tb_time_weighted_dac_average.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_time_weighted_dac_average: self-checking bench for the averaging DAC
// Streams write and read requests with random gaps on both sides, predicts
// every averaged sample with an in-bench model of the accumulator, and
// compares each sample leaving m_axis against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_time_weighted_dac_average;
  import twda_pkg::*;

  localparam int unsigned SUM_WIDTH   = 48;
  localparam logic [63:0] SUM_MAX     = (64'd1 << SUM_WIDTH) - 64'd1;
  localparam logic        KIND_WRITE  = 1'b0;
  localparam logic        KIND_READ   = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // long enough for any request still in flight when the last sample
  // has been seen to finish in the unit
  localparam int unsigned SETTLE      = 120;
  localparam int unsigned LONG_HOLD   = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [79:0]         s_axis_tdata = '0;   // [63:0] now_clock, [79:64] dac_value
  logic                s_axis_tuser = 1'b0; // [0] kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SampleW-1:0]  m_axis_tdata;   // [23:0] sample
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  time_weighted_dac_average #(.SUM_WIDTH(SUM_WIDTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Averaging model: mirrors the block's registers and accumulator
  // ------------------------------------------------------------------------
  logic [ShiftW-1:0] mdl_dac_bits;
  logic [GainW-1:0]  mdl_gain;
  logic [FsW-1:0]    mdl_full_scale;
  logic [DacW-1:0]   mdl_held      = '0;
  logic [63:0]       mdl_last_clk  = '0;
  logic [63:0]       mdl_win_start = '0;
  logic [63:0]       mdl_sum       = '0;  // never exceeds SUM_MAX

  logic [SampleW-1:0] expected_samples[$];
  item_t              pending_requests[$];

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;
  int unsigned cycle_count = 0;

  // Fold the held code over the elapsed clocks into the accumulator,
  // then either latch a new code or emit the window average.
  task automatic apply_dac_event(input item_t req);
    logic [63:0]        elapsed;
    logic [63:0]        prod;
    logic [63:0]        ticks;
    logic [127:0]       scaled;
    logic [127:0]       quot;
    logic [SampleW-1:0] smp;
    begin
      // elapsed wraps mod 2^64, so a clock going backwards is a long interval
      elapsed = req.now_clock - mdl_last_clk;
      if (mdl_held != 0 && elapsed > SUM_MAX / {48'd0, mdl_held})
        prod = SUM_MAX;
      else
        prod = elapsed * {48'd0, mdl_held};
      if (prod > SUM_MAX - mdl_sum)
        mdl_sum = SUM_MAX;
      else
        mdl_sum = mdl_sum + prod;
      mdl_last_clk = req.now_clock;

      if (req.is_read == KIND_WRITE) begin
        mdl_held = req.dac_value;
      end else begin
        ticks = req.now_clock - mdl_win_start;
        smp   = '0;
        // empty window and zero gain both give 0
        if (ticks != 0 && mdl_gain != 0) begin
          scaled = ({64'd0, mdl_sum} * {112'd0, mdl_full_scale}) >> mdl_dac_bits;
          quot   = scaled / {64'd0, ticks};
          if (quot > {104'd0, SAMPLE_MAX} / {120'd0, mdl_gain})
            smp = SAMPLE_MAX;
          else
            smp = quot[SampleW-1:0] * {16'd0, mdl_gain};
        end
        expected_samples.push_back(smp);
        mdl_sum       = '0;
        mdl_win_start = req.now_clock;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [SampleW-1:0] want,
                                 input logic [SampleW-1:0] got);
    begin
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
      n_errors++;
    end
  endtask

  // mostly back-to-back, sometimes a short gap, rarely a long pause
  function automatic int unsigned next_gap();
    int unsigned r;
    begin
      r = $urandom_range(0, 99);
      if (r < 60)      next_gap = 0;
      else if (r < 90) next_gap = $urandom_range(1, 3);
      else if (r < 98) next_gap = $urandom_range(4, 20);
      else             next_gap = $urandom_range(30, 150);
    end
  endfunction

  // ------------------------------------------------------------------------
  // Request driver
  // ------------------------------------------------------------------------
  item_t       tx_cur;
  int unsigned tx_gap_left = 0;
  bit          tx_burst = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_dac_event(tx_cur);
        n_accepted++;
      end
      // a request on offer stays put until taken
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (tx_gap_left != 0) begin
          tx_gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          tx_cur = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {tx_cur.dac_value, tx_cur.now_clock};
          s_axis_tuser  <= tx_cur.is_read;
          tx_gap_left = tx_burst ? 0 : next_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Sample monitor and checker
  // ------------------------------------------------------------------------
  int unsigned        rx_stall_left = 0;
  int unsigned        rx_hold_left  = 0;
  bit                 rx_hold_req   = 1'b0;
  bit                 rx_hold_done  = 1'b0;
  bit                 rx_burst      = 1'b0;
  logic [SampleW-1:0] rx_want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample", '0, m_axis_tdata);
        end else begin
          rx_want = expected_samples.pop_front();
          if (m_axis_tdata !== rx_want)
            report_mismatch("sample", rx_want, m_axis_tdata);
        end
      end
      // long hold-off: counted here so the sender keeps pushing meanwhile
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_req && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        rx_hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready && !rx_burst) begin
        rx_stall_left = next_gap();
        m_axis_tready <= (rx_stall_left == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[%0t] timeout, %0d samples outstanding", $time, expected_samples.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  logic [63:0] gen_clk = '0;

  task automatic add_request(input logic kind, input logic [63:0] now,
                             input logic [DacW-1:0] code);
    item_t req;
    begin
      req.is_read   = kind;
      req.now_clock = now;
      req.dac_value = code;
      pending_requests.push_back(req);
      n_queued++;
    end
  endtask

  // clock mostly moves forward in small steps; sometimes it stalls,
  // leaps, jumps anywhere or steps back
  task automatic add_random_request(input bit read_only);
    int unsigned     r;
    logic            kind;
    logic [DacW-1:0] code;
    begin
      r = $urandom_range(0, 99);
      if (r < 70)      gen_clk = gen_clk + 64'($urandom_range(1, 2000));
      else if (r < 85) gen_clk = gen_clk + {32'd0, $urandom};
      else if (r < 90) gen_clk = gen_clk;
      else if (r < 94) gen_clk = {$urandom, $urandom};
      else if (r < 97) gen_clk = gen_clk - 64'($urandom_range(1, 1000));
      else             gen_clk = gen_clk + (64'd1 << $urandom_range(32, 62));
      kind = (read_only || $urandom_range(0, 99) < 40) ? KIND_READ : KIND_WRITE;
      r = $urandom_range(0, 99);
      if (r < 15)      code = '0;
      else if (r < 30) code = '1;
      else if (r < 40) code = 16'($urandom_range(1, 15));
      else             code = 16'($urandom_range(0, 65535));
      add_request(kind, gen_clk, code);
    end
  endtask

  task automatic wait_idle();
    begin
      while (n_accepted != n_queued || expected_samples.size() != 0)
        @(posedge clk_i);
      // writes leave nothing to wait for, so give the unit time to finish
      repeat (SETTLE) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= val;
      case (idx)
        CFG_DAC_BITS:   mdl_dac_bits   = val[ShiftW-1:0];
        CFG_GAIN:       mdl_gain       = val[GainW-1:0];
        CFG_FULL_SCALE: mdl_full_scale = val[FsW-1:0];
        default: ;
      endcase
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
    end
  endtask

  task automatic set_config(input logic [ShiftW-1:0] shift, input logic [GainW-1:0] g,
                            input logic [FsW-1:0] fs);
    begin
      write_reg(CFG_DAC_BITS, {11'd0, shift});
      write_reg(CFG_GAIN, {8'd0, g});
      write_reg(CFG_FULL_SCALE, fs);
    end
  endtask

  logic [ShiftW-1:0] cfg_shift_tbl[5] = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd8};
  logic [GainW-1:0]  cfg_gain_tbl[5]  = '{8'd255, 8'd1, 8'd255, 8'd0, 8'd17};
  logic [FsW-1:0]    cfg_fs_tbl[5]    = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd30000, 16'd0};

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DAC_BITS;
    cfg_wdata_i   = '0;

    mdl_dac_bits   = DAC_BITS_RST;
    mdl_gain       = GAIN_RST;
    mdl_full_scale = FULL_SCALE_RST;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset register values
    add_request(KIND_READ,  64'd0, 16'd0);            // empty window right after reset
    add_request(KIND_WRITE, 64'd100, 16'hFFFF);
    add_request(KIND_READ,  64'd200, 16'd0);
    add_request(KIND_WRITE, 64'd300, 16'd0);
    add_request(KIND_WRITE, 64'd400, 16'd1);
    add_request(KIND_READ,  64'd1000, 16'hABCD);      // code ignored on read
    add_request(KIND_READ,  64'd1000, 16'd0);         // zero-length window
    add_request(KIND_WRITE, 64'd1000, 16'hFFFF);
    add_request(KIND_READ,  64'd1000 + (64'd1 << 40), 16'd0); // accumulator saturates
    add_request(KIND_WRITE, 64'd50, 16'd5);           // clock runs backwards
    add_request(KIND_READ,  64'd60, 16'd0);
    add_request(KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h8000);
    add_request(KIND_READ,  64'd0, 16'd0);            // elapsed wraps to one
    add_request(KIND_READ,  64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
    add_request(KIND_WRITE, 64'h5555_5555_5555_5555, 16'h1234);
    add_request(KIND_READ,  64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
    add_request(KIND_WRITE, 64'hAAAA_AAAA_AAAA_AAAB, 16'hAAAA);
    add_request(KIND_READ,  64'hAAAA_AAAA_AAAA_ABAB, 16'd0);
    wait_idle();

    // receiver blocks for a long stretch while reads keep coming, so the
    // request queue fills and tready drops
    tx_burst    = 1'b1;
    rx_hold_req = 1'b1;
    gen_clk     = 64'hAAAA_AAAA_AAAA_ABAB;
    repeat (32) add_random_request(1'b1);
    wait_idle();
    tx_burst = 1'b0;

    // extreme settings first, then random ones
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 5) begin
        set_config(cfg_shift_tbl[ph], cfg_gain_tbl[ph], cfg_fs_tbl[ph]);
      end else begin
        set_config(($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 16)),
                   8'($urandom_range(0, 255)), 16'($urandom_range(1, 65535)));
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      repeat (210) add_random_request(1'b0);
      wait_idle();
    end

    if (n_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: time_weighted_dac_average.f
design/twda_pkg.sv
design/twda_front.sv
design/twda_back.sv
design/time_weighted_dac_average.sv
design/twda_checker.sv
bench/tb_time_weighted_dac_average.sv
